// ===== design/imuf_pkg.sv =====
package imuf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQRT,
    ST_CLOAD,
    ST_CITER,
    ST_CDONE,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_DIV,
    ST_DQ,
    ST_INC,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_DONE
  } imuf_state_t;

  localparam logic [1:0] CFG_BLEND_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_RATE_SCALE   = 2'd1;

  localparam logic [1:0] AXIS_PITCH = 2'd0;
  localparam logic [1:0] AXIS_ROLL  = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  localparam int ZW = 36;
  localparam int AW = ZW - 8;
  localparam logic signed [ZW-1:0] HALF_TURN_Q24 = 36'sd3019898880;
  localparam logic [9:0] DIVISOR = 10'd1000;
  localparam logic [9:0] DIV_ROUND = 10'd500;
  localparam int DIGIT_W = 11;
  localparam int DIV_SHIFT = 31;
  localparam logic [21:0] DIV_RECIP = 22'd2147484;

  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      5'd24: v = 30'd57;
      5'd25: v = 30'd29;
      5'd26: v = 30'd14;
      5'd27: v = 30'd7;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/imu_complementary_filter_core.sv =====
// Per input word, one sequencer runs the bit-serial square root, two atan2 runs on the
// shared CORDIC stage and three reciprocal divides by 1000 of DCH 11-bit digits each.
// Each atan2 of a zero vector skips its CORDIC_ITERATIONS steps.
// A new word is taken in the cycle after the result registers; in_stall holds off new
// words while a word is in work, and an unread result holds the next one in its last state.
module imu_complementary_filter_core
  import imuf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_x,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_y,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_z,
  input  logic        [9:0]              elapsed_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             pitch_out,
  output logic signed [31:0]             roll_out,
  output logic signed [31:0]             yaw_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [1:0]              cfg_index,
  input  logic        [23:0]             cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = SW + 27;
  localparam int QW = 2 * SW;
  localparam int RW = SW + 17;
  localparam int VW = SW + 27;
  localparam int MA = (SW + 17 > 32) ? SW + 17 : 32;
  localparam int MB = (SW > 25) ? SW : 25;
  localparam int PW = MA + MB;
  localparam int SATW = PW + 1;
  localparam int CNTW = $clog2(VW + 1);
  localparam int DCH = (VW + DIGIT_W - 1) / DIGIT_W;
  localparam int DW = DCH * DIGIT_W;
  localparam int DVW = 10 + DIGIT_W;
  localparam logic signed [SATW-1:0] SMAX = SATW'(32'sh7FFF_FFFF);
  localparam logic signed [SATW-1:0] SMIN = SATW'(32'sh8000_0000);

  function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
    logic signed [31:0] r;
    if (v > SMAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SMIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  imuf_state_t state, state_next;

  logic        [15:0]    blend_weight;
  logic        [23:0]    rate_scale;
  logic signed [31:0]    pitch_angle, roll_angle, yaw_angle;
  logic signed [SW-1:0]  ax, ay, az, rx, ry, rz;
  logic        [9:0]     dt;
  logic        [QW-1:0]  sq, sres, sbit;
  logic signed [CW-1:0]  cx, cy;
  logic signed [ZW-1:0]  cz;
  logic signed [AW-1:0]  acc_pitch, acc_roll;
  logic signed [PW-1:0]  prod;
  logic signed [RW-1:0]  rr;
  logic        [DW-1:0]  dm;
  logic        [9:0]     drem;
  logic                  dneg;
  logic signed [31:0]    bpred;
  logic signed [SATW-1:0] bsum;
  logic        [CNTW-1:0] cnt;
  logic                  phase;
  logic        [1:0]     axis;

  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic                  mul_en;

  logic signed [SW-1:0]  rate_sel;
  logic signed [AW-1:0]  acc_sel;
  logic signed [31:0]    angle_sel;
  logic signed [CW-1:0]  yv, xv, xs, ys;
  logic        [QW-1:0]  strial;
  logic        [DVW-1:0] dval;
  logic        [DIGIT_W-1:0] dq;
  logic signed [VW:0]    inc;
  logic signed [VW-1:0]  vprod;
  logic        [4:0]     sh;
  logic signed [ZW-1:0]  tab;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    unique case (axis)
      AXIS_PITCH: rate_sel = rx;
      AXIS_ROLL:  rate_sel = ry;
      default:    rate_sel = rz;
    endcase
    acc_sel = (axis == AXIS_PITCH) ? acc_pitch : acc_roll;
    angle_sel = (axis == AXIS_PITCH) ? pitch_angle : roll_angle;
    yv = phase ? -CW'(ax) : CW'(ay);
    xv = phase ? CW'({1'b0, sres[SW-1:0]}) : CW'(az);
    sh = cnt[4:0];
    xs = cx >>> sh;
    ys = cy >>> sh;
    tab = $signed(ZW'(atan_entry(sh)));
    strial = sres + sbit;
    dval = {drem, dm[DW-1 -: DIGIT_W]};
    dq = prod[DIV_SHIFT +: DIGIT_W];
    vprod = prod[VW-1:0];
    inc = dneg ? -$signed({1'b0, dm[VW-1:0]}) : $signed({1'b0, dm[VW-1:0]});
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ0: begin
        mul_a = MA'(ay);
        mul_b = MB'(ay);
      end
      ST_SQ1: begin
        mul_a = MA'(az);
        mul_b = MB'(az);
      end
      ST_G0: begin
        mul_a = MA'(rate_sel);
        mul_b = MB'({1'b0, rate_scale});
      end
      ST_G2: begin
        mul_a = MA'(rr);
        mul_b = MB'({1'b0, dt});
      end
      ST_DIV: begin
        mul_a = MA'({1'b0, dval});
        mul_b = MB'({1'b0, DIV_RECIP});
      end
      ST_B0: begin
        mul_a = MA'(bpred);
        mul_b = MB'({1'b0, blend_weight});
      end
      ST_B1: begin
        mul_a = MA'(acc_sel);
        mul_b = MB'(18'sd65536 - $signed({2'b00, blend_weight}));
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SQ0;
      ST_SQ0: state_next = ST_SQ1;
      ST_SQ1: state_next = ST_SQ2;
      ST_SQ2: state_next = ST_SQRT;
      ST_SQRT: if (cnt == CNTW'(SW - 1)) state_next = ST_CLOAD;
      ST_CLOAD: state_next = (xv == '0 && yv == '0) ? ST_CDONE : ST_CITER;
      ST_CITER: if (cnt == CNTW'(CORDIC_ITERATIONS - 1)) state_next = ST_CDONE;
      ST_CDONE: state_next = phase ? ST_G0 : ST_CLOAD;
      ST_G0: state_next = ST_G1;
      ST_G1: state_next = ST_G2;
      ST_G2: state_next = ST_G3;
      ST_G3: state_next = ST_DIV;
      ST_DIV: state_next = ST_DQ;
      ST_DQ: state_next = (cnt == CNTW'(DCH - 1)) ? ST_INC : ST_DIV;
      ST_INC: state_next = (axis == AXIS_YAW) ? ST_DONE : ST_B0;
      ST_B0: state_next = ST_B1;
      ST_B1: state_next = ST_B2;
      ST_B2: state_next = ST_G0;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= 16'd62915;
      rate_scale <= 24'd1023472;
      pitch_angle <= '0;
      roll_angle <= '0;
      yaw_angle <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BLEND_WEIGHT) begin
          blend_weight <= cfg_data[15:0];
        end else if (cfg_index == CFG_RATE_SCALE) begin
          rate_scale <= cfg_data;
        end
      end
      if (state == ST_B2) begin
        if (axis == AXIS_PITCH) begin
          pitch_angle <= sat32((bsum + SATW'(prod) + SATW'(32768)) >>> 16);
        end else begin
          roll_angle <= sat32((bsum + SATW'(prod) + SATW'(32768)) >>> 16);
        end
      end
      if (state == ST_INC && axis == AXIS_YAW) begin
        yaw_angle <= sat32(SATW'(yaw_angle) + SATW'(inc));
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (state)
      ST_IDLE: begin
        ax <= accel_x;
        ay <= accel_y;
        az <= accel_z;
        rx <= rate_x;
        ry <= rate_y;
        rz <= rate_z;
        dt <= elapsed_ms;
      end
      ST_SQ1: sq <= prod[QW-1:0];
      ST_SQ2: begin
        sq <= sq + prod[QW-1:0];
        sres <= '0;
        sbit <= QW'(1) << (QW - 2);
        cnt <= '0;
        phase <= 1'b0;
      end
      ST_SQRT: begin
        if (sq >= strial) begin
          sq <= sq - strial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        cnt <= cnt + 1'b1;
      end
      ST_CLOAD: begin
        cnt <= '0;
        if (xv < 0) begin
          cz <= (yv >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
          cx <= (-xv) <<< 24;
          cy <= (-yv) <<< 24;
        end else begin
          cz <= '0;
          cx <= xv <<< 24;
          cy <= yv <<< 24;
        end
      end
      ST_CITER: begin
        if (cy >= 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + tab;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - tab;
        end
        cnt <= cnt + 1'b1;
      end
      ST_CDONE: begin
        if (phase) begin
          acc_roll <= AW'((cz + ZW'(128)) >>> 8);
          axis <= AXIS_PITCH;
        end else begin
          acc_pitch <= AW'((cz + ZW'(128)) >>> 8);
          phase <= 1'b1;
        end
      end
      ST_G1: rr <= RW'((prod + PW'(128)) >>> 8);
      ST_G3: begin
        dneg <= vprod < 0;
        dm <= DW'(((vprod < 0) ? VW'(-vprod) : VW'(vprod)) + VW'(DIV_ROUND));
        drem <= '0;
        cnt <= '0;
      end
      ST_DQ: begin
        drem <= 10'(dval - DVW'(dq) * DVW'(DIVISOR));
        dm <= {dm[DW-DIGIT_W-1:0], dq};
        cnt <= cnt + 1'b1;
      end
      ST_INC: bpred <= sat32(SATW'(angle_sel) + SATW'(inc));
      ST_B1: bsum <= SATW'(prod);
      ST_B2: axis <= axis + 1'b1;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          pitch_out <= pitch_angle;
          roll_out <= roll_angle;
          yaw_out <= yaw_angle;
        end
      end
      default: ;
    endcase
  end

endmodule
